// ===== rtl/des_block_cipher_defines.svh =====
// Assertion helpers for the cipher RTL.
`ifndef DES_BLOCK_CIPHER_DEFINES_SVH
`define DES_BLOCK_CIPHER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define DES_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DES_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/des_pkg.sv =====
`default_nettype none
package des_pkg;

    localparam int DES_ROUNDS  = 16;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 64;
    localparam int KEY_W       = 64;
    localparam int BLOCK_W     = 64;
    localparam int HALF_W      = 32;
    localparam int CD_W        = 56;
    localparam int C_W         = 28;
    localparam int RK_W        = 48;

    localparam logic [PADDR_W-1:0] ADDR_KEY = 4'h0;

    localparam byte unsigned IP_TAB [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7 };

    localparam byte unsigned FP_TAB [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25 };

    localparam byte unsigned E_TAB [48] = '{
        32,1,2,3,4,5,     4,5,6,7,8,9,
        8,9,10,11,12,13,  12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25,
        24,25,26,27,28,29, 28,29,30,31,32,1 };

    localparam byte unsigned P_TAB [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25 };

    localparam byte unsigned PC1_TAB [56] = '{
        57,49,41,33,25,17,9,  1,58,50,42,34,26,18,
        10,2,59,51,43,35,27,  19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29,  21,13,5,28,20,12,4 };

    localparam byte unsigned PC2_TAB [48] = '{
        14,17,11,24,1,5,   3,28,15,6,21,10,
        23,19,12,4,26,8,   16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48,
        44,49,39,56,34,53, 46,42,50,36,29,32 };

    // rotation of two places where set, one place otherwise
    localparam logic [15:0] ROT2_TAB = 16'b0111_1110_1111_1100;

    localparam byte unsigned SBOX_TAB [8][64] = '{
      '{ 14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
         0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
         4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
         15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13 },
      '{ 15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
         3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
         0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
         13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9 },
      '{ 10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
         13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
         13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
         1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12 },
      '{ 7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
         13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
         10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
         3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14 },
      '{ 2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
         14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
         4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
         11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3 },
      '{ 12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
         10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
         9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
         4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13 },
      '{ 4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
         13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
         1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
         6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12 },
      '{ 13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
         1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
         7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
         2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11 } };

    typedef struct packed {
        logic busy;
        logic we;
    } ks_status_t;

    function automatic logic [BLOCK_W-1:0] des_ip(input logic [BLOCK_W-1:0] src);
        logic [BLOCK_W-1:0] r;
        for (int i = 0; i < 64; i++) begin
            r[63-i] = src[64 - int'(IP_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [BLOCK_W-1:0] des_fp(input logic [BLOCK_W-1:0] src);
        logic [BLOCK_W-1:0] r;
        for (int i = 0; i < 64; i++) begin
            r[63-i] = src[64 - int'(FP_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [CD_W-1:0] des_pc1(input logic [KEY_W-1:0] src);
        logic [CD_W-1:0] r;
        for (int i = 0; i < 56; i++) begin
            r[55-i] = src[64 - int'(PC1_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [RK_W-1:0] des_pc2(input logic [CD_W-1:0] src);
        logic [RK_W-1:0] r;
        for (int i = 0; i < 48; i++) begin
            r[47-i] = src[56 - int'(PC2_TAB[i])];
        end
        return r;
    endfunction

    function automatic logic [HALF_W-1:0] des_f(input logic [HALF_W-1:0] rh,
                                                 input logic [RK_W-1:0]   rk);
        logic [RK_W-1:0]   x;
        logic [HALF_W-1:0] s;
        logic [HALF_W-1:0] p;
        logic [5:0]        six;
        byte unsigned      sv;
        for (int i = 0; i < 48; i++) begin
            x[47-i] = rh[32 - int'(E_TAB[i])];
        end
        x = x ^ rk;
        for (int i = 0; i < 8; i++) begin
            six = x[47-6*i -: 6];
            sv  = SBOX_TAB[i][{six[5], six[0], six[4:1]}];
            s[31-4*i -: 4] = sv[3:0];
        end
        for (int i = 0; i < 32; i++) begin
            p[31-i] = s[32 - int'(P_TAB[i])];
        end
        return p;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/des_key_sched.sv =====
`default_nettype none
module des_key_sched
    import des_pkg::*;
#(
    parameter int ROUNDS = DES_ROUNDS,
    localparam int CNT_W = $clog2(ROUNDS)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [KEY_W-1:0]  key,
    output ks_status_t             status,
    output logic      [CNT_W-1:0]  waddr,
    output logic      [RK_W-1:0]   wdata
);

    localparam logic [CNT_W-1:0] LAST = CNT_W'(ROUNDS - 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CD_W-1:0]  cd_reg;
    logic [CD_W-1:0]  cd_next;
    logic [C_W-1:0]   c_cur;
    logic [C_W-1:0]   d_cur;

    assign c_cur = cd_reg[CD_W-1:C_W];
    assign d_cur = cd_reg[C_W-1:0];

    always_comb begin
        if (ROT2_TAB[cnt_reg]) begin
            cd_next = {c_cur[C_W-3:0], c_cur[C_W-1:C_W-2],
                       d_cur[C_W-3:0], d_cur[C_W-1:C_W-2]};
        end else begin
            cd_next = {c_cur[C_W-2:0], c_cur[C_W-1],
                       d_cur[C_W-2:0], d_cur[C_W-1]};
        end
    end

    assign wdata     = des_pc2(cd_next);
    assign waddr     = cnt_reg;
    assign status.busy = busy_reg;
    assign status.we   = busy_reg;

    // sweep the schedule once after reset (zero key) and after every key write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            cd_reg   <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            cd_reg   <= des_pc1(key);
        end else if (busy_reg) begin
            cd_reg  <= cd_next;
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/des_block_cipher.sv =====
// DES block cipher, one 64-bit block per input beat.
// Input stream: s_tdata carries the block (first byte in the top bits),
// s_tuser selects encrypt (0) or decrypt (1). Output stream: m_tdata
// carries the result block. The key lives in an APB register at
// address 0; a write starts a round key sweep into a 16 x 48
// single-port-write memory, during which s_tready stays low.
// After reset the same sweep runs with the all-zero key before
// the first beat is taken.
// Flow: accept, then the rounds (one Feistel round per cycle, one
// round key read per cycle from the key memory), then the final
// permutation into the output register from the hold state; the block
// then goes idle and can take a new beat while the result still waits.
// If the receiver stalls, the result holds in the output register; the
// next block still runs its rounds and then waits until the register is
// free. Reset clears the control state and drops any block in flight.
`default_nettype none
`include "des_block_cipher_defines.svh"
module des_block_cipher
    import des_pkg::*;
#(
    parameter int ROUNDS = DES_ROUNDS
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic      [PDATA_W-1:0]  prdata,
    output logic                     pready,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [BLOCK_W-1:0]  s_tdata,   // [63:0] data_block
    input  wire logic                s_tuser,   // [0] func
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [BLOCK_W-1:0]  m_tdata    // [63:0] result_block
);

    localparam int CNT_W = $clog2(ROUNDS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ROUNDS - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_HOLD} state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_inc;
    logic              func_reg;
    logic [HALF_W-1:0] l_reg;
    logic [HALF_W-1:0] r_reg;
    logic [BLOCK_W-1:0] ip_blk;
    logic [HALF_W-1:0] f_out;
    logic [KEY_W-1:0]  key_reg;
    logic              m_tvalid_reg;
    logic [BLOCK_W-1:0] m_tdata_reg;
    logic              key_wr;
    logic              s_beat;
    logic              out_free;

    logic [RK_W-1:0]   rk_mem [ROUNDS];
    logic [RK_W-1:0]   rk_rdata_reg;
    logic [CNT_W-1:0]  rk_raddr;
    logic [CNT_W-1:0]  ks_waddr;
    logic [RK_W-1:0]   ks_wdata;
    ks_status_t        ks_status;

    assign pready  = 1'b1;
    assign key_wr  = psel && penable && pwrite && (paddr == ADDR_KEY);
    assign prdata  = (paddr == ADDR_KEY) ? key_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (key_wr) begin
            key_reg <= pwdata;
        end
    end

    des_key_sched #(
        .ROUNDS (ROUNDS)
    ) u_key_sched (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (key_wr),
        .key     (pwdata),
        .status  (ks_status),
        .waddr   (ks_waddr),
        .wdata   (ks_wdata)
    );

    always_ff @(posedge aclk) begin
        if (ks_status.we) begin
            rk_mem[ks_waddr] <= ks_wdata;
        end
        rk_rdata_reg <= rk_mem[rk_raddr];
    end

    assign s_tready = (state_reg == ST_IDLE) && !ks_status.busy;
    assign s_beat   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign cnt_inc  = cnt_reg + 1'b1;
    assign ip_blk   = des_ip(s_tdata);
    assign f_out    = des_f(r_reg, rk_rdata_reg);

    // fetch the key for the round after the one in progress (in idle, the first round's key)
    always_comb begin
        if (state_reg == ST_IDLE) begin
            rk_raddr = s_tuser ? LAST : '0;
        end else begin
            rk_raddr = func_reg ? (LAST - cnt_inc) : cnt_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if ((state_reg == ST_HOLD) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_beat) begin
                        func_reg  <= s_tuser;
                        l_reg     <= ip_blk[BLOCK_W-1:HALF_W];
                        r_reg     <= ip_blk[HALF_W-1:0];
                        cnt_reg   <= '0;
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    l_reg   <= r_reg;
                    r_reg   <= l_reg ^ f_out;
                    cnt_reg <= cnt_inc;
                    if (cnt_reg == LAST) begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        m_tdata_reg  <= des_fp({r_reg, l_reg});
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `DES_ASSERT_SAME(a_no_beat_in_sweep, aclk, aresetn, ks_status.busy, !s_tready, "beat taken during key sweep")
    `DES_ASSERT_NEXT(a_beat_starts_rounds, aclk, aresetn, s_beat, (state_reg == ST_ROUND) && (cnt_reg == '0), "accepted beat did not start round 1")
    `DES_ASSERT_NEXT(a_last_round_holds, aclk, aresetn, (state_reg == ST_ROUND) && (cnt_reg == LAST), state_reg == ST_HOLD, "rounds did not end after the last key")

endmodule
`default_nettype wire

// ===== tb/des_block_cipher_test.sv =====
`timescale 1ns / 1ps

import des_pkg::*;

class cipher_ledger;
    bit [KEY_W-1:0]   key_value;
    bit [RK_W-1:0]    round_keys [DES_ROUNDS];
    bit [BLOCK_W-1:0] pending_results [$];
    bit [BLOCK_W-1:0] last_result;
    bit               last_decrypt;
    int               checked;
    int               failures;
    int               n_encrypt;
    int               n_decrypt;

    function new();
        load_key('0);
    endfunction

    // PC-1, per-round rotation of both halves, PC-2
    function void load_key(bit [KEY_W-1:0] k);
        bit [CD_W-1:0] cd;
        bit [C_W-1:0]  c;
        bit [C_W-1:0]  d;
        int            shift;
        key_value = k;
        for (int i = 0; i < CD_W; i++) begin
            cd[CD_W-1-i] = k[KEY_W - int'(PC1_TAB[i])];
        end
        c = cd[CD_W-1:C_W];
        d = cd[C_W-1:0];
        for (int r = 0; r < DES_ROUNDS; r++) begin
            shift = (r == 0 || r == 1 || r == 8 || r == 15) ? 1 : 2;
            repeat (shift) begin
                c = {c[C_W-2:0], c[C_W-1]};
                d = {d[C_W-2:0], d[C_W-1]};
            end
            cd = {c, d};
            for (int i = 0; i < RK_W; i++) begin
                round_keys[r][RK_W-1-i] = cd[CD_W - int'(PC2_TAB[i])];
            end
        end
    endfunction

    function bit [HALF_W-1:0] round_fn(bit [HALF_W-1:0] rh, bit [RK_W-1:0] rk);
        bit [RK_W-1:0]   x;
        bit [HALF_W-1:0] s;
        bit [HALF_W-1:0] p;
        bit [5:0]        six;
        int              row;
        int              col;
        for (int i = 0; i < RK_W; i++) begin
            x[RK_W-1-i] = rh[HALF_W - int'(E_TAB[i])];
        end
        x ^= rk;
        for (int i = 0; i < 8; i++) begin
            six = x[RK_W-1-6*i -: 6];
            row = {six[5], six[0]};
            col = six[4:1];
            s[HALF_W-1-4*i -: 4] = 4'(SBOX_TAB[i][row * 16 + col]);
        end
        for (int i = 0; i < HALF_W; i++) begin
            p[HALF_W-1-i] = s[HALF_W - int'(P_TAB[i])];
        end
        return p;
    endfunction

    function bit [BLOCK_W-1:0] crypt(bit decrypt, bit [BLOCK_W-1:0] blk);
        bit [BLOCK_W-1:0] ip;
        bit [BLOCK_W-1:0] pre;
        bit [BLOCK_W-1:0] res;
        bit [HALF_W-1:0]  lh;
        bit [HALF_W-1:0]  rh;
        bit [HALF_W-1:0]  t;
        for (int i = 0; i < BLOCK_W; i++) begin
            ip[BLOCK_W-1-i] = blk[BLOCK_W - int'(IP_TAB[i])];
        end
        lh = ip[BLOCK_W-1:HALF_W];
        rh = ip[HALF_W-1:0];
        for (int r = 0; r < DES_ROUNDS; r++) begin
            t  = lh ^ round_fn(rh, round_keys[decrypt ? DES_ROUNDS - 1 - r : r]);
            lh = rh;
            rh = t;
        end
        pre = {rh, lh};
        for (int i = 0; i < BLOCK_W; i++) begin
            res[BLOCK_W-1-i] = pre[BLOCK_W - int'(FP_TAB[i])];
        end
        return res;
    endfunction

    function void note_failure(string what, bit [BLOCK_W-1:0] want, logic [BLOCK_W-1:0] got);
        failures++;
        if (failures <= 10) begin
            $display("tb: mismatch on %s: expected %h, got %h", what, want, got);
        end
    endfunction

    function void note_block(bit decrypt, bit [BLOCK_W-1:0] blk);
        last_result  = crypt(decrypt, blk);
        last_decrypt = decrypt;
        pending_results.push_back(last_result);
        if (decrypt) n_decrypt++;
        else n_encrypt++;
    endfunction

    function void check_block(logic [BLOCK_W-1:0] got);
        bit [BLOCK_W-1:0] want;
        if (pending_results.size() == 0) begin
            note_failure("unexpected result beat", '0, got);
        end else begin
            want = pending_results.pop_front();
            checked++;
            if (got !== want) note_failure("result_block", want, got);
        end
    endfunction
endclass

module des_block_cipher_test;

    localparam int                 STALL_LIMIT = 4000;
    localparam int                 SEG_ITEMS   = 193;
    localparam logic [PADDR_W-1:0] ADDR_SPARE  = 4'h8;

    logic               aclk;
    logic               aresetn  = 1'b0;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = ADDR_KEY;
    logic [PDATA_W-1:0] pwdata   = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [BLOCK_W-1:0] s_tdata  = '0;   // [63:0] data_block
    logic               s_tuser  = 1'b0; // [0] func
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [BLOCK_W-1:0] m_tdata;         // [63:0] result_block

    cipher_ledger ledger = new();
    int           send_idle   = 31;
    int           recv_idle   = 84;
    int           stall_count = 0;
    int           key_writes  = 0;

    des_block_cipher dut (
        .aclk, .aresetn,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // check result beats; drop the run if nothing moves for too long
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) ledger.check_block(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) stall_count = 0;
        else stall_count++;
        if (stall_count >= STALL_LIMIT) begin
            $display("tb: stalled for %0d cycles", stall_count);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_block(input bit decrypt, input bit [BLOCK_W-1:0] blk);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= decrypt;
        s_tdata  <= blk;
        do @(posedge aclk); while (!s_tready);
        ledger.note_block(decrypt, blk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (ledger.pending_results.size() != 0) @(posedge aclk);
    endtask

    // write, then read the key back in the following transfer
    task automatic write_register(input logic [PADDR_W-1:0] addr,
                                  input logic [KEY_W-1:0] value);
        logic [PDATA_W-1:0] got;
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_KEY) begin
            ledger.load_key(value);
            key_writes++;
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_KEY;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== ledger.key_value) ledger.note_failure("key readback", ledger.key_value, got);
        @(posedge aclk);
    endtask

    initial begin
        cipher_ledger       probe;
        logic [KEY_W-1:0]   kv;
        probe = new();
        probe.load_key(64'h1334_5779_9BBC_DFF1);
        if (probe.crypt(1'b0, 64'h0123_4567_89AB_CDEF) != 64'h85E8_1354_0F0A_B405)
            ledger.note_failure("predictor known answer", 64'h85E8_1354_0F0A_B405,
                                probe.crypt(1'b0, 64'h0123_4567_89AB_CDEF));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // all-zero schedule straight after reset
        push_block(1'b0, '0);
        push_block(1'b1, '0);
        push_block(1'b0, '1);
        push_block(1'b1, '1);
        push_block(1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
        push_block(1'b1, 64'h5555_5555_5555_5555);
        push_block(1'b0, 64'h8000_0000_0000_0000);
        push_block(1'b0, 64'h0000_0000_0000_0001);

        write_register(ADDR_KEY, 64'h1334_5779_9BBC_DFF1);
        push_block(1'b0, 64'h0123_4567_89AB_CDEF);
        push_block(1'b1, 64'h85E8_1354_0F0A_B405);

        // out-of-range register: key must stay as it was
        write_register(ADDR_SPARE, {$urandom, $urandom});
        push_block(1'b0, 64'h0123_4567_89AB_CDEF);

        write_register(ADDR_KEY, '1);
        push_block(1'b0, '0);
        push_block(1'b1, '1);
        push_block(1'b0, 64'h0123_4567_89AB_CDEF);

        write_register(ADDR_KEY, 64'h0101_0101_0101_0101);
        push_block(1'b0, '0);
        push_block(1'b1, '0);

        for (int seg = 0; seg < 9; seg++) begin
            if (seg == 3) begin
                send_idle = 84;
                recv_idle = 31;
            end
            if (seg == 6) begin
                send_idle = 0;
                recv_idle = 0;
            end
            case (seg)
                0: kv = '1;
                4: kv = '0;
                8: kv = 64'hFEFE_FEFE_FEFE_FEFE;
                default: kv = {$urandom, $urandom};
            endcase
            write_register(ADDR_KEY, kv);
            for (int n = 0; n < SEG_ITEMS; n++) begin
                if ($urandom_range(3) == 0) push_block(!ledger.last_decrypt, ledger.last_result);
                else push_block(1'($urandom_range(1)), {$urandom, $urandom});
            end
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        if (ledger.pending_results.size() != 0) begin
            $display("tb: %0d results never arrived", ledger.pending_results.size());
            ledger.failures += ledger.pending_results.size();
        end
        $display("tb: %0d blocks checked (%0d encrypt, %0d decrypt) under %0d key writes,",
                 ledger.checked, ledger.n_encrypt, ledger.n_decrypt, key_writes);
        $display("tb: with sender-heavy, receiver-heavy and back-to-back flow control");
        if (ledger.failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
